>>> rtl/core/tsm_pkg.sv
// ----------------------------------------------------------------------------
// tsm_pkg
// Shared types and constants of the tolerant sequence matcher.
// ----------------------------------------------------------------------------
package tsm_pkg;

    // Default sizes
    localparam int POOL_DEPTH_DEF    = 1024;
    localparam int PATTERN_DEPTH_DEF = 64;
    localparam int GAP_BITS_DEF      = 16;

    // Fixed field widths
    localparam int TOL_BITS     = 16;
    localparam int IN_GAP_BITS  = 16;
    localparam int TAG_BITS     = 32;
    localparam int REQ_BITS     = 2;
    localparam int CNT_OUT_BITS = 11;
    localparam int POS_OUT_BITS = 10;
    localparam int LEN_OUT_BITS = 7;

    localparam int IN_TDATA_BITS  = 48;
    localparam int OUT_TDATA_BITS = 64;

    localparam logic [TOL_BITS-1:0] TOL_RESET = 16'd10;

    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    typedef enum logic [REQ_BITS-1:0] {
        REQ_LOAD    = 2'd0,
        REQ_APPEND  = 2'd1,
        REQ_CLR_PAT = 2'd2,
        REQ_CLR_ALL = 2'd3
    } req_t;

    typedef struct packed {
        logic                    status;
        logic [CNT_OUT_BITS-1:0] match_count;
        logic [POS_OUT_BITS-1:0] first_position;
        logic [TAG_BITS-1:0]     end_tag;
        logic [LEN_OUT_BITS-1:0] pattern_length;
    } res_t;

endpackage

>>> rtl/core/tolerant_sequence_matcher_top.sv
// ----------------------------------------------------------------------------
// tolerant_sequence_matcher_top
// Pool of recorded gaps with tags, growing pattern, tolerant pattern search.
// ----------------------------------------------------------------------------
// Each request produces exactly one result. Load and clear requests go from
// idle straight to the done state. An append request whose pattern fits in
// the pool first runs the search, with C element comparisons: every start
// position from 0 to pool count minus pattern length is tried, and each
// start compares pattern elements in order until the first one out of
// tolerance, so C is at most (pool count - pattern length + 1) * pattern
// length. Each comparison is one registered read of the pool and pattern
// memories, then one pass through the single compare unit. The done state
// of a request is held while the output register still holds a result that
// the sink has not taken. The input is not ready while a request is in work;
// a finished result waits in the output register while the next request is
// taken. The tolerance register may be written at any time the block is idle.
module tolerant_sequence_matcher_top #(
    parameter int POOL_DEPTH    = tsm_pkg::POOL_DEPTH_DEF,
    parameter int PATTERN_DEPTH = tsm_pkg::PATTERN_DEPTH_DEF,
    parameter int GAP_BITS      = tsm_pkg::GAP_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // request stream
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // [15:0] gap_value, [47:16] tag_word
    input  logic [tsm_pkg::IN_TDATA_BITS-1:0]  s_tdata,
    // [1:0] req_type
    input  logic [tsm_pkg::REQ_BITS-1:0]       s_tuser,
    // result stream
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // [10:0] match_count, [20:11] first_position, [52:21] end_tag,
    // [59:53] pattern_length, [63:60] zero
    output logic [tsm_pkg::OUT_TDATA_BITS-1:0] m_tdata,
    // [0] status
    output logic                               m_tuser,
    // tolerance write
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [tsm_pkg::TOL_BITS-1:0]       cfg_data
);
    import tsm_pkg::*;

    localparam int PAW = $clog2(POOL_DEPTH);
    localparam int TAW = (PATTERN_DEPTH > 1) ? $clog2(PATTERN_DEPTH) : 1;
    localparam int PAD_BITS = OUT_TDATA_BITS - CNT_OUT_BITS - POS_OUT_BITS
                              - TAG_BITS - LEN_OUT_BITS;

    logic                pool_wr_en;
    logic [PAW-1:0]      pool_wr_addr;
    logic [GAP_BITS-1:0] wr_gap;
    logic [PAW-1:0]      pool_rd_addr;
    logic [GAP_BITS-1:0] pool_rd_gap;
    logic [TAG_BITS-1:0] pool_rd_tag;
    logic                pat_wr_en;
    logic [TAW-1:0]      pat_wr_addr;
    logic [TAW-1:0]      pat_rd_addr;
    logic [GAP_BITS-1:0] pat_rd_gap;
    logic                res_free;
    logic                res_valid;
    res_t                res;
    logic                out_valid_reg, out_valid_next;
    res_t                out_res_reg;

    assign cfg_ready = 1'b1;
    assign res_free  = !out_valid_reg || m_tready;

    tsm_pool_mem #(
        .POOL_DEPTH (POOL_DEPTH),
        .GAP_BITS   (GAP_BITS),
        .PAW        (PAW)
    ) u_pool (
        .clk     (clk),
        .wr_en   (pool_wr_en),
        .wr_addr (pool_wr_addr),
        .wr_gap  (wr_gap),
        .wr_tag  (s_tdata[IN_GAP_BITS +: TAG_BITS]),
        .rd_addr (pool_rd_addr),
        .rd_gap  (pool_rd_gap),
        .rd_tag  (pool_rd_tag)
    );

    tsm_pat_mem #(
        .PATTERN_DEPTH (PATTERN_DEPTH),
        .GAP_BITS      (GAP_BITS),
        .TAW           (TAW)
    ) u_pat (
        .clk     (clk),
        .wr_en   (pat_wr_en),
        .wr_addr (pat_wr_addr),
        .wr_gap  (wr_gap),
        .rd_addr (pat_rd_addr),
        .rd_gap  (pat_rd_gap)
    );

    tsm_seq #(
        .POOL_DEPTH    (POOL_DEPTH),
        .PATTERN_DEPTH (PATTERN_DEPTH),
        .GAP_BITS      (GAP_BITS),
        .PAW           (PAW),
        .TAW           (TAW)
    ) u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (s_tvalid),
        .req_ready    (s_tready),
        .req_type     (s_tuser),
        .gap_value    (s_tdata[IN_GAP_BITS-1:0]),
        .cfg_valid    (cfg_valid),
        .cfg_data     (cfg_data),
        .pool_wr_en   (pool_wr_en),
        .pool_wr_addr (pool_wr_addr),
        .wr_gap       (wr_gap),
        .pool_rd_addr (pool_rd_addr),
        .pool_rd_gap  (pool_rd_gap),
        .pool_rd_tag  (pool_rd_tag),
        .pat_wr_en    (pat_wr_en),
        .pat_wr_addr  (pat_wr_addr),
        .pat_rd_addr  (pat_rd_addr),
        .pat_rd_gap   (pat_rd_gap),
        .res_free     (res_free),
        .res_valid    (res_valid),
        .res          (res)
    );

    // Output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_valid)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
            out_res_reg <= res;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_res_reg.status;
    assign m_tdata  = {{PAD_BITS{1'b0}},
                       out_res_reg.pattern_length,
                       out_res_reg.end_tag,
                       out_res_reg.first_position,
                       out_res_reg.match_count};

    // Assertions
    a_busy_after_request: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input still ready right after a request was taken");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (!out_valid_reg || m_tready))
        else $error("result written over a pending output");

    a_no_match_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.match_count == '0) |->
            (res.first_position == '0 && res.end_tag == '0))
        else $error("position or tag set without a match");

endmodule

>>> rtl/core/tsm_pool_mem.sv
// ----------------------------------------------------------------------------
// tsm_pool_mem
// Pool store: gap and tag per entry, one write port, one registered read port.
// ----------------------------------------------------------------------------
module tsm_pool_mem #(
    parameter int POOL_DEPTH = tsm_pkg::POOL_DEPTH_DEF,
    parameter int GAP_BITS   = tsm_pkg::GAP_BITS_DEF,
    parameter int PAW        = $clog2(POOL_DEPTH)
) (
    input  logic                         clk,
    input  logic                         wr_en,
    input  logic [PAW-1:0]               wr_addr,
    input  logic [GAP_BITS-1:0]          wr_gap,
    input  logic [tsm_pkg::TAG_BITS-1:0] wr_tag,
    input  logic [PAW-1:0]               rd_addr,
    output logic [GAP_BITS-1:0]          rd_gap,
    output logic [tsm_pkg::TAG_BITS-1:0] rd_tag
);
    import tsm_pkg::*;

    logic [GAP_BITS-1:0] gap_mem [POOL_DEPTH];
    logic [TAG_BITS-1:0] tag_mem [POOL_DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            gap_mem[wr_addr] <= wr_gap;
            tag_mem[wr_addr] <= wr_tag;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_gap <= gap_mem[rd_addr];
        rd_tag <= tag_mem[rd_addr];
    end

endmodule

>>> rtl/core/tsm_pat_mem.sv
// ----------------------------------------------------------------------------
// tsm_pat_mem
// Pattern store: one gap per element, one write port, one registered read.
// ----------------------------------------------------------------------------
module tsm_pat_mem #(
    parameter int PATTERN_DEPTH = tsm_pkg::PATTERN_DEPTH_DEF,
    parameter int GAP_BITS      = tsm_pkg::GAP_BITS_DEF,
    parameter int TAW           = (PATTERN_DEPTH > 1) ? $clog2(PATTERN_DEPTH) : 1
) (
    input  logic                clk,
    input  logic                wr_en,
    input  logic [TAW-1:0]      wr_addr,
    input  logic [GAP_BITS-1:0] wr_gap,
    input  logic [TAW-1:0]      rd_addr,
    output logic [GAP_BITS-1:0] rd_gap
);
    import tsm_pkg::*;

    logic [GAP_BITS-1:0] gap_mem [PATTERN_DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            gap_mem[wr_addr] <= wr_gap;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_gap <= gap_mem[rd_addr];
    end

endmodule

>>> rtl/core/tsm_cmp.sv
// ----------------------------------------------------------------------------
// tsm_cmp
// Shared compare unit: absolute gap difference against the tolerance.
// ----------------------------------------------------------------------------
module tsm_cmp #(
    parameter int GAP_BITS = tsm_pkg::GAP_BITS_DEF
) (
    input  logic [GAP_BITS-1:0]          pool_gap,
    input  logic [GAP_BITS-1:0]          pat_gap,
    input  logic [tsm_pkg::TOL_BITS-1:0] tol,
    output logic                         hit
);
    import tsm_pkg::*;

    localparam int DW = (GAP_BITS > TOL_BITS) ? GAP_BITS : TOL_BITS;

    logic [GAP_BITS-1:0] diff;

    always_comb
    begin
        if (pool_gap >= pat_gap)
            diff = pool_gap - pat_gap;
        else
            diff = pat_gap - pool_gap;
        hit = DW'(diff) <= DW'(tol);
    end

endmodule

>>> rtl/core/tsm_seq.sv
// ----------------------------------------------------------------------------
// tsm_seq
// Request sequencer: pool and pattern bookkeeping and the search walk that
// runs every comparison through the single compare unit.
// ----------------------------------------------------------------------------
module tsm_seq #(
    parameter int POOL_DEPTH    = tsm_pkg::POOL_DEPTH_DEF,
    parameter int PATTERN_DEPTH = tsm_pkg::PATTERN_DEPTH_DEF,
    parameter int GAP_BITS      = tsm_pkg::GAP_BITS_DEF,
    parameter int PAW           = $clog2(POOL_DEPTH),
    parameter int TAW           = (PATTERN_DEPTH > 1) ? $clog2(PATTERN_DEPTH) : 1
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // request side
    input  logic                            req_valid,
    output logic                            req_ready,
    input  logic [tsm_pkg::REQ_BITS-1:0]    req_type,
    input  logic [tsm_pkg::IN_GAP_BITS-1:0] gap_value,
    // tolerance write
    input  logic                            cfg_valid,
    input  logic [tsm_pkg::TOL_BITS-1:0]    cfg_data,
    // pool store
    output logic                            pool_wr_en,
    output logic [PAW-1:0]                  pool_wr_addr,
    output logic [GAP_BITS-1:0]             wr_gap,
    output logic [PAW-1:0]                  pool_rd_addr,
    input  logic [GAP_BITS-1:0]             pool_rd_gap,
    input  logic [tsm_pkg::TAG_BITS-1:0]    pool_rd_tag,
    // pattern store
    output logic                            pat_wr_en,
    output logic [TAW-1:0]                  pat_wr_addr,
    output logic [TAW-1:0]                  pat_rd_addr,
    input  logic [GAP_BITS-1:0]             pat_rd_gap,
    // result
    input  logic                            res_free,
    output logic                            res_valid,
    output tsm_pkg::res_t                   res
);
    import tsm_pkg::*;

    localparam int PCW = $clog2(POOL_DEPTH + 1);
    localparam int TCW = $clog2(PATTERN_DEPTH + 1);
    localparam int CW  = (PCW > TCW) ? PCW : TCW;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_CMP,
        ST_DONE
    } state_t;

    state_t              state_reg, state_next;
    logic [TOL_BITS-1:0] tol_reg, tol_next;
    logic [PCW-1:0]      pool_cnt_reg, pool_cnt_next;
    logic [TCW-1:0]      pat_cnt_reg, pat_cnt_next;
    logic [PAW-1:0]      start_reg, start_next;
    logic [TAW-1:0]      idx_reg, idx_next;
    logic [PCW-1:0]      match_reg, match_next;
    logic [PAW-1:0]      first_reg, first_next;
    logic                found_reg, found_next;
    logic [TAG_BITS-1:0] end_tag_reg, end_tag_next;
    logic                status_reg, status_next;

    logic                hit;
    logic                advance;
    logic                start_last;
    logic                idx_last;
    logic [CW-1:0]       rd_sum;
    req_t                req;

    tsm_cmp #(
        .GAP_BITS (GAP_BITS)
    ) u_cmp (
        .pool_gap (pool_rd_gap),
        .pat_gap  (pat_rd_gap),
        .tol      (tol_reg),
        .hit      (hit)
    );

    assign req        = req_t'(req_type);
    assign req_ready  = (state_reg == ST_IDLE);
    assign wr_gap     = GAP_BITS'(gap_value);
    assign rd_sum     = CW'(start_reg) + CW'(idx_reg);
    assign pool_rd_addr = rd_sum[PAW-1:0];
    assign pat_rd_addr  = idx_reg;
    assign pool_wr_addr = pool_cnt_reg[PAW-1:0];
    assign pat_wr_addr  = pat_cnt_reg[TAW-1:0];
    assign start_last = CW'(start_reg) == (CW'(pool_cnt_reg) - CW'(pat_cnt_reg));
    assign idx_last   = (CW'(idx_reg) + CW'(1)) == CW'(pat_cnt_reg);

    assign res.status         = status_reg;
    assign res.match_count    = CNT_OUT_BITS'(match_reg);
    assign res.first_position = POS_OUT_BITS'(first_reg);
    assign res.end_tag        = end_tag_reg;
    assign res.pattern_length = LEN_OUT_BITS'(pat_cnt_reg);

    always_comb
    begin
        state_next    = state_reg;
        tol_next      = tol_reg;
        pool_cnt_next = pool_cnt_reg;
        pat_cnt_next  = pat_cnt_reg;
        start_next    = start_reg;
        idx_next      = idx_reg;
        match_next    = match_reg;
        first_next    = first_reg;
        found_next    = found_reg;
        end_tag_next  = end_tag_reg;
        status_next   = status_reg;
        pool_wr_en    = 1'b0;
        pat_wr_en     = 1'b0;
        res_valid     = 1'b0;
        advance       = 1'b0;

        if (cfg_valid)
            tol_next = cfg_data;

        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    status_next  = STATUS_OK;
                    match_next   = '0;
                    first_next   = '0;
                    found_next   = 1'b0;
                    end_tag_next = '0;
                    start_next   = '0;
                    idx_next     = '0;
                    state_next   = ST_DONE;
                    case (req)
                        REQ_LOAD:
                        begin
                            if (CW'(pool_cnt_reg) >= CW'(POOL_DEPTH))
                                status_next = STATUS_FULL;
                            else
                            begin
                                pool_wr_en    = 1'b1;
                                pool_cnt_next = pool_cnt_reg + PCW'(1);
                            end
                        end
                        REQ_APPEND:
                        begin
                            if (CW'(pat_cnt_reg) >= CW'(PATTERN_DEPTH))
                                status_next = STATUS_FULL;
                            else
                            begin
                                pat_wr_en    = 1'b1;
                                pat_cnt_next = pat_cnt_reg + TCW'(1);
                            end
                            // search only when the pattern fits in the pool
                            if (CW'(pat_cnt_next) <= CW'(pool_cnt_reg))
                                state_next = ST_READ;
                        end
                        REQ_CLR_PAT:
                        begin
                            pat_cnt_next = '0;
                        end
                        REQ_CLR_ALL:
                        begin
                            pat_cnt_next  = '0;
                            pool_cnt_next = '0;
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                state_next = ST_CMP;
            end
            ST_CMP:
            begin
                advance = 1'b1;
                if (hit)
                begin
                    if (idx_last)
                    begin
                        match_next = match_reg + PCW'(1);
                        if (!found_reg)
                        begin
                            found_next   = 1'b1;
                            first_next   = start_reg;
                            end_tag_next = pool_rd_tag;
                        end
                    end
                    else
                    begin
                        idx_next   = idx_reg + TAW'(1);
                        state_next = ST_READ;
                        advance    = 1'b0;
                    end
                end
                // leave this start, on a miss or a full match, and move to the next one
                if (advance)
                begin
                    if (start_last)
                        state_next = ST_DONE;
                    else
                    begin
                        start_next = start_reg + PAW'(1);
                        idx_next   = '0;
                        state_next = ST_READ;
                    end
                end
            end
            ST_DONE:
            begin
                // hold until the output register can take the result
                if (res_free)
                begin
                    res_valid  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            tol_reg      <= TOL_RESET;
            pool_cnt_reg <= '0;
            pat_cnt_reg  <= '0;
            start_reg    <= '0;
            idx_reg      <= '0;
            match_reg    <= '0;
            first_reg    <= '0;
            found_reg    <= 1'b0;
            end_tag_reg  <= '0;
            status_reg   <= STATUS_OK;
        end
        else
        begin
            state_reg    <= state_next;
            tol_reg      <= tol_next;
            pool_cnt_reg <= pool_cnt_next;
            pat_cnt_reg  <= pat_cnt_next;
            start_reg    <= start_next;
            idx_reg      <= idx_next;
            match_reg    <= match_next;
            first_reg    <= first_next;
            found_reg    <= found_next;
            end_tag_reg  <= end_tag_next;
            status_reg   <= status_next;
        end
    end

endmodule

>>> tb/tolerant_sequence_matcher_top_tb.sv
// ----------------------------------------------------------------------------
// tolerant_sequence_matcher_top_tb
// Self-checking bench for the tolerant sequence matcher. A scoreboard keeps
// its own copy of the pool, the pattern and the tolerance, predicts one
// result per accepted request and checks the result stream in order. The
// stimulus runs a short directed list, fills the pattern to its limit, then
// runs mixed phases of loads and near-copy pattern runs under several
// tolerance settings, with random gaps on both streams.
// ----------------------------------------------------------------------------
module tolerant_sequence_matcher_top_tb;

    import tsm_pkg::*;

    localparam int CLK_PERIOD = 12;
    localparam int POOL_SIZE  = POOL_DEPTH_DEF;
    localparam int PAT_SIZE   = PATTERN_DEPTH_DEF;

    class match_scoreboard;
        logic [TOL_BITS-1:0]    tolerance;
        logic [IN_GAP_BITS-1:0] pool_gap [POOL_SIZE];
        logic [TAG_BITS-1:0]    pool_tag [POOL_SIZE];
        int                     pool_used;
        logic [IN_GAP_BITS-1:0] pattern_gap [PAT_SIZE];
        int                     pattern_used;
        res_t                   search_results_due [$];
        int                     errors;
        int                     requests_noted;
        int                     results_seen;
        int                     drops_predicted;
        int                     best_count;

        function new();
            tolerance       = TOL_RESET;
            pool_used       = 0;
            pattern_used    = 0;
            errors          = 0;
            requests_noted  = 0;
            results_seen    = 0;
            drops_predicted = 0;
            best_count      = 0;
        endfunction

        function int pending();
            return search_results_due.size();
        endfunction

        function void set_tolerance(logic [TOL_BITS-1:0] value);
            tolerance = value;
        endfunction

        // Apply one request to the shadow state and queue its outcome.
        function void note_request(req_t req, logic [IN_GAP_BITS-1:0] gap,
                                   logic [TAG_BITS-1:0] tag);
            res_t                   outcome;
            int                     hits;
            int                     s;
            int                     k;
            bit                     fits;
            logic [IN_GAP_BITS-1:0] diff;

            outcome = '0;
            hits    = 0;
            requests_noted++;
            case (req)
                REQ_LOAD:
                begin
                    if (pool_used >= POOL_SIZE)
                    begin
                        outcome.status = STATUS_FULL;
                    end
                    else
                    begin
                        pool_gap[pool_used] = gap;
                        pool_tag[pool_used] = tag;
                        pool_used++;
                    end
                end
                REQ_APPEND:
                begin
                    if (pattern_used >= PAT_SIZE)
                    begin
                        outcome.status = STATUS_FULL;
                    end
                    else
                    begin
                        pattern_gap[pattern_used] = gap;
                        pattern_used++;
                    end
                    // search runs even when the element was dropped
                    if (pattern_used >= 1 && pattern_used <= pool_used)
                    begin
                        for (s = 0; s <= pool_used - pattern_used; s++)
                        begin
                            fits = 1'b1;
                            for (k = 0; k < pattern_used && fits; k++)
                            begin
                                diff = (pool_gap[s+k] >= pattern_gap[k]) ?
                                       pool_gap[s+k] - pattern_gap[k] :
                                       pattern_gap[k] - pool_gap[s+k];
                                if (diff > tolerance)
                                    fits = 1'b0;
                            end
                            if (fits)
                            begin
                                if (hits == 0)
                                begin
                                    outcome.first_position = POS_OUT_BITS'(s);
                                    outcome.end_tag = pool_tag[s + pattern_used - 1];
                                end
                                hits++;
                            end
                        end
                    end
                    outcome.match_count = CNT_OUT_BITS'(hits);
                end
                REQ_CLR_PAT:
                begin
                    pattern_used = 0;
                end
                default:
                begin
                    pattern_used = 0;
                    pool_used    = 0;
                end
            endcase
            outcome.pattern_length = LEN_OUT_BITS'(pattern_used);
            if (outcome.status == STATUS_FULL)
                drops_predicted++;
            if (hits > best_count)
                best_count = hits;
            search_results_due = {search_results_due, outcome};
        endfunction

        task report(string what);
            errors++;
            $display("MISMATCH at %0t: %s", $realtime, what);
        endtask

        task check_result(res_t got);
            res_t want;
            results_seen++;
            if (search_results_due.size() == 0)
            begin
                report($sformatf("result %0d arrived with none outstanding", results_seen));
                return;
            end
            want = search_results_due.pop_front();
            if (got.status !== want.status)
                report($sformatf("result %0d status %0b, want %0b",
                                 results_seen, got.status, want.status));
            if (got.match_count !== want.match_count)
                report($sformatf("result %0d match_count %0d, want %0d",
                                 results_seen, got.match_count, want.match_count));
            if (got.first_position !== want.first_position)
                report($sformatf("result %0d first_position %0d, want %0d",
                                 results_seen, got.first_position, want.first_position));
            if (got.end_tag !== want.end_tag)
                report($sformatf("result %0d end_tag %h, want %h",
                                 results_seen, got.end_tag, want.end_tag));
            if (got.pattern_length !== want.pattern_length)
                report($sformatf("result %0d pattern_length %0d, want %0d",
                                 results_seen, got.pattern_length, want.pattern_length));
        endtask
    endclass

    logic                      clk;
    logic                      rst_n;
    logic                      s_tvalid;
    logic                      s_tready;
    logic [IN_TDATA_BITS-1:0]  s_tdata;
    logic [REQ_BITS-1:0]       s_tuser;
    logic                      m_tvalid;
    logic                      m_tready;
    logic [OUT_TDATA_BITS-1:0] m_tdata;
    logic                      m_tuser;
    logic                      cfg_valid;
    logic                      cfg_ready;
    logic [TOL_BITS-1:0]       cfg_data;

    match_scoreboard sb_match;
    int              source_quiet;
    int              sink_quiet;

    tolerant_sequence_matcher_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #(CLK_PERIOD / 2);
        clk = 1'b1;
        #(CLK_PERIOD / 2);
    end

    // Random idle gap, with occasional stretches of back-to-back traffic.
    function automatic int next_wait(inout int quiet);
        if (quiet > 0)
        begin
            quiet--;
            return 0;
        end
        if ($urandom_range(0, 19) == 0)
            quiet = $urandom_range(10, 40);
        return $urandom_range(0, 9);
    endfunction

    function automatic logic [IN_GAP_BITS-1:0] pick_gap();
        case ($urandom_range(0, 3))
            0:       return IN_GAP_BITS'($urandom);
            1:       return IN_GAP_BITS'(500 + $urandom_range(0, 24));
            2:       return IN_GAP_BITS'(16'hFFFF - $urandom_range(0, 24));
            default: return IN_GAP_BITS'($urandom_range(0, 24));
        endcase
    endfunction

    // Copy of a pool gap moved by nothing, the tolerance, one past it, or less.
    function automatic logic [IN_GAP_BITS-1:0] near_gap(logic [IN_GAP_BITS-1:0] base,
                                                        logic [TOL_BITS-1:0] tol);
        int off;
        int v;
        case ($urandom_range(0, 3))
            0:       off = 0;
            1:       off = int'(tol);
            2:       off = int'(tol) + 1;
            default: off = $urandom_range(0, int'(tol));
        endcase
        v = $urandom_range(0, 1) ? int'(base) + off : int'(base) - off;
        if (v < 0)
            v = 0;
        if (v > 65535)
            v = 65535;
        return IN_GAP_BITS'(v);
    endfunction

    task automatic send_request(req_t req, logic [IN_GAP_BITS-1:0] gap,
                                logic [TAG_BITS-1:0] tag);
        int idle;
        idle = next_wait(source_quiet);
        if (idle != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (idle) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {tag, gap};
        s_tuser  <= req;
        do @(posedge clk); while (!s_tready);
        sb_match.note_request(req, gap, tag);
    endtask

    // Write only once every outstanding result is back.
    task automatic write_tolerance(logic [TOL_BITS-1:0] value);
        s_tvalid <= 1'b0;
        do @(posedge clk); while (sb_match.pending() != 0);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb_match.set_tolerance(value);
    endtask

    task automatic run_mixed_phase(logic [TOL_BITS-1:0] tol, int budget, int pool_cap);
        int   issued;
        int   roll;
        int   start;
        int   len;
        int   k;
        req_t req;
        write_tolerance(tol);
        send_request(REQ_CLR_ALL, IN_GAP_BITS'($urandom), $urandom);
        issued = 1;
        while (issued < budget)
        begin
            roll = $urandom_range(0, 9);
            if (sb_match.pool_used < pool_cap && (sb_match.pool_used < 4 || roll < 2))
            begin
                send_request(REQ_LOAD, pick_gap(), $urandom);
                issued++;
            end
            else if (roll < 8 && sb_match.pool_used > 0)
            begin
                // restart the pattern and replay a pool window with noise
                send_request(REQ_CLR_PAT, IN_GAP_BITS'($urandom), $urandom);
                start = $urandom_range(0, sb_match.pool_used - 1);
                len   = sb_match.pool_used - start;
                if (len > 8)
                    len = 8;
                len = $urandom_range(1, len);
                for (k = 0; k < len; k++)
                    send_request(REQ_APPEND, near_gap(sb_match.pool_gap[start+k], tol),
                                 $urandom);
                issued += len + 1;
            end
            else
            begin
                req = req_t'($urandom_range(0, 3));
                if (req == REQ_CLR_ALL && $urandom_range(0, 3) != 0)
                    req = REQ_APPEND;
                if (req == REQ_LOAD && sb_match.pool_used >= pool_cap)
                    req = REQ_APPEND;
                send_request(req, IN_GAP_BITS'($urandom), $urandom);
                issued++;
            end
        end
    endtask

    initial
    begin
        int k;

        sb_match     = new();
        source_quiet = 0;
        sink_quiet   = 0;
        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = REQ_LOAD;
        m_tready     = 1'b0;
        cfg_valid    = 1'b0;
        cfg_data     = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: reset tolerance, empty pool, tolerance edge, extremes, clears.
        send_request(REQ_APPEND, 16'd0, 32'h0000_0000);
        send_request(REQ_CLR_PAT, 16'hFFFF, 32'hFFFF_FFFF);
        send_request(REQ_LOAD, 16'd0, 32'h0000_0000);
        send_request(REQ_LOAD, 16'hFFFF, 32'hFFFF_FFFF);
        send_request(REQ_LOAD, 16'd100, 32'hA5A5_0002);
        send_request(REQ_LOAD, 16'd110, 32'h5A5A_0003);
        send_request(REQ_LOAD, 16'd89, 32'h1234_0004);
        send_request(REQ_LOAD, 16'd90, 32'h8765_0005);
        send_request(REQ_APPEND, 16'd100, $urandom);
        send_request(REQ_APPEND, 16'd100, $urandom);
        send_request(REQ_APPEND, 16'd0, $urandom);
        send_request(REQ_CLR_PAT, 16'd0, 32'h0);
        send_request(REQ_APPEND, 16'hFFFF, $urandom);
        send_request(REQ_APPEND, 16'hFFFF, $urandom);
        send_request(REQ_CLR_ALL, 16'hFFFF, 32'hFFFF_FFFF);
        send_request(REQ_APPEND, 16'd5, $urandom);
        write_tolerance(16'd0);
        send_request(REQ_CLR_PAT, 16'd0, 32'h0);
        send_request(REQ_LOAD, 16'd7, 32'hC0DE_0000);
        send_request(REQ_LOAD, 16'd7, 32'hC0DE_0001);
        send_request(REQ_LOAD, 16'd8, 32'hC0DE_0002);
        send_request(REQ_APPEND, 16'd7, $urandom);
        send_request(REQ_APPEND, 16'd8, $urandom);

        // Fill the pattern to its limit, then push past it.
        write_tolerance(16'd40);
        send_request(REQ_CLR_ALL, 16'd0, 32'h0);
        for (k = 0; k < PAT_SIZE + 3; k++)
            send_request(REQ_LOAD, pick_gap(), $urandom);
        for (k = 0; k < PAT_SIZE; k++)
            send_request(REQ_APPEND, near_gap(sb_match.pool_gap[k], 16'd40), $urandom);
        for (k = 0; k < 3; k++)
            send_request(REQ_APPEND, IN_GAP_BITS'($urandom), $urandom);

        // Mixed random phases under several tolerances.
        run_mixed_phase(16'd0, 68, 40);
        run_mixed_phase(TOL_RESET, 68, 48);
        run_mixed_phase(16'hFFFF, 68, 24);
        run_mixed_phase(16'd3, 68, 40);
        run_mixed_phase(16'd150, 68, 32);
        run_mixed_phase(TOL_BITS'($urandom), 68, 48);

        s_tvalid <= 1'b0;
        while (sb_match.pending() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("Covered %0d requests and %0d results; %0d full-store drops.",
                 sb_match.requests_noted, sb_match.results_seen,
                 sb_match.drops_predicted);
        $display("Top match count %0d; tolerance went through 0, 3, 10, 40, 150, %s",
                 sb_match.best_count, "65535 and one random value.");
        if (sb_match.errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Result side: random stalls, in-order check of every accepted result.
    initial
    begin
        int   stall;
        res_t got;
        @(posedge rst_n);
        forever
        begin
            stall = next_wait(sink_quiet);
            if (stall != 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
            got                = '0;
            got.status         = m_tuser;
            got.match_count    = m_tdata[10:0];
            got.first_position = m_tdata[20:11];
            got.end_tag        = m_tdata[52:21];
            got.pattern_length = m_tdata[59:53];
            sb_match.check_result(got);
        end
    end

    initial
    begin
        #(CLK_PERIOD * 5_000_000);
        $display("Run timed out with %0d results outstanding.", sb_match.pending());
        $display("end of test: mismatches");
        $finish;
    end

endmodule

>>> sim.f
rtl/core/tsm_pkg.sv
rtl/core/tsm_pool_mem.sv
rtl/core/tsm_pat_mem.sv
rtl/core/tsm_cmp.sv
rtl/core/tsm_seq.sv
rtl/core/tolerant_sequence_matcher_top.sv
tb/tolerant_sequence_matcher_top_tb.sv
